FILE: rtl/core/lhpc_pkg.sv
// ----------------------------------------------------------------------------
// lhpc_pkg: shared types and constants for the lift height PID controller
// Register indexes, field widths, drive constants and the structs passed
// between the front stage and the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lhpc_pkg;

  localparam int unsigned PosW   = 24;  // target, encoder, offset
  localparam int unsigned GainW  = 16;
  localparam int unsigned BandW  = 23;
  localparam int unsigned FloorW = 31;
  localparam int unsigned ErrW   = 26;  // target - (enc - offset)
  localparam int unsigned DerW   = 27;  // err - previous err
  localparam int unsigned IntW   = 32;
  localparam int unsigned DrvW   = 8;
  localparam int unsigned SumW   = 50;  // sum of the three gain products
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 31;

  localparam logic signed [DrvW-1:0] DRIVE_MAX      = 8'sd80;
  localparam logic signed [DrvW-1:0] DRIVE_MIN      = -8'sd80;
  localparam logic signed [DrvW-1:0] DRIVE_GND_HOLD = -8'sd7;
  localparam logic signed [DrvW-1:0] DRIVE_GND_RUN  = -8'sd50;
  localparam logic signed [DrvW-1:0] DRIVE_UP_HOLD  = 8'sd10;
  // 110 requested on the way up, already clamped to the drive limit
  localparam logic signed [DrvW-1:0] DRIVE_UP_RUN   = 8'sd80;

  localparam logic signed [IntW-1:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [IntW-1:0] INT_MIN = 32'sh8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_P    = 3'd0,
    CFG_GAIN_I    = 3'd1,
    CFG_GAIN_D    = 3'd2,
    CFG_BAND      = 3'd3,
    CFG_FLOOR     = 3'd4,
    CFG_GND_CODE  = 3'd5,
    CFG_STASH_CODE = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [GainW-1:0] gain_p;
    logic signed [GainW-1:0] gain_i;
    logic signed [GainW-1:0] gain_d;
    logic [BandW-1:0]        arrive_band;
    logic [FloorW-1:0]       integral_floor;
    logic signed [PosW-1:0]  ground_code;
    logic signed [PosW-1:0]  stash_code;
  } cfg_t;

  // register values after reset: all zero but the stash code
  localparam cfg_t CFG_RESET = '{
    gain_p:         16'sd0,
    gain_i:         16'sd0,
    gain_d:         16'sd0,
    arrive_band:    23'd0,
    integral_floor: 31'd0,
    ground_code:    24'sd0,
    stash_code:     24'sd1
  };

  typedef struct packed {
    logic                   action;
    logic signed [PosW-1:0] target_height;
    logic signed [PosW-1:0] encoder_count;
    logic                   low_switch;
    logic                   high_switch;
  } in_item_t;

  // front stage result: either a fixed drive or PID terms for the multipliers
  typedef struct packed {
    logic                   use_pid;
    logic signed [DrvW-1:0] fixed_drive;
    logic                   done;
    logic signed [ErrW-1:0] err;
    logic signed [IntW-1:0] integ;
    logic signed [DerW-1:0] deriv;
  } stage_t;

endpackage

`default_nettype wire

FILE: rtl/core/lhpc_front.sv
// ----------------------------------------------------------------------------
// lhpc_front: mode decode, error, integral and derivative
// Holds the controller memory (previous error, integral, zero offset) and
// registers the terms handed to the multiply stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lhpc_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lhpc_pkg::cfg_t    cfg_i,
  input  wire lhpc_pkg::in_item_t item_i,
  input  wire logic              step_i,
  output lhpc_pkg::stage_t       stage_o
);
  import lhpc_pkg::*;

  logic signed [ErrW-1:0] prev_err_q, prev_err_d;
  logic signed [IntW-1:0] integ_q, integ_d;
  logic signed [PosW-1:0] offset_q, offset_d;
  stage_t                 stage_q, stage_d;

  logic                   is_ground, is_stash, pid_step;
  logic signed [PosW-1:0] off_use;
  logic signed [PosW:0]   height;
  logic signed [ErrW-1:0] err;
  logic signed [IntW:0]   int_sum;
  logic signed [IntW-1:0] int_sat, int_new;
  logic signed [DerW-1:0] err_mag, clr_lim, band_s;
  logic signed [IntW:0]   int_mag, floor_s;

  always_comb begin
    is_ground = (item_i.target_height == cfg_i.ground_code);
    is_stash  = !is_ground && (item_i.target_height == cfg_i.stash_code);
    pid_step  = step_i && !item_i.action && !is_ground && !is_stash;

    // a pressed low switch re-zeroes the height before it is used
    off_use = item_i.low_switch ? item_i.encoder_count : offset_q;
    height  = (PosW+1)'(item_i.encoder_count) - (PosW+1)'(off_use);
    err     = ErrW'(item_i.target_height) - ErrW'(height);

    int_sum = (IntW+1)'(integ_q) + (IntW+1)'(err);
    if (int_sum[IntW] != int_sum[IntW-1]) begin
      int_sat = int_sum[IntW] ? INT_MIN : INT_MAX;
    end else begin
      int_sat = int_sum[IntW-1:0];
    end

    err_mag = err[ErrW-1] ? -DerW'(err) : DerW'(err);
    band_s  = $signed({{(DerW-BandW){1'b0}}, cfg_i.arrive_band});
    clr_lim = DerW'(item_i.target_height) + band_s;
    int_mag = int_sat[IntW-1] ? -(IntW+1)'(int_sat) : (IntW+1)'(int_sat);
    floor_s = $signed({{(IntW+1-FloorW){1'b0}}, cfg_i.integral_floor});
    int_new = ((err_mag <= clr_lim) || (int_mag <= floor_s)) ? '0 : int_sat;
  end

  always_comb begin
    stage_d       = stage_q;
    prev_err_d    = prev_err_q;
    integ_d       = integ_q;
    offset_d      = offset_q;
    if (step_i) begin
      stage_d.use_pid     = 1'b0;
      stage_d.fixed_drive = '0;
      stage_d.done        = 1'b0;
      stage_d.err         = err;
      stage_d.integ       = int_new;
      stage_d.deriv       = DerW'(err) - DerW'(prev_err_q);
      if (item_i.action) begin
        prev_err_d = '0;
        integ_d    = '0;
      end else if (is_ground) begin
        stage_d.fixed_drive = item_i.low_switch ? DRIVE_GND_HOLD : DRIVE_GND_RUN;
        stage_d.done        = item_i.low_switch;
      end else if (is_stash) begin
        stage_d.fixed_drive = item_i.high_switch ? DRIVE_UP_HOLD : DRIVE_UP_RUN;
        stage_d.done        = item_i.high_switch;
      end else begin
        stage_d.use_pid = 1'b1;
        stage_d.done    = (err_mag <= band_s);
        prev_err_d      = err;
        integ_d         = int_new;
        offset_d        = off_use;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      integ_q    <= '0;
      offset_q   <= '0;
    end else begin
      prev_err_q <= prev_err_d;
      integ_q    <= integ_d;
      offset_q   <= offset_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign stage_o = stage_q;

  a_clear_zeroes_memory : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.action |=> (prev_err_q == '0) && (integ_q == '0))
    else $error("clear request left PID memory nonzero");

  a_low_switch_rezero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pid_step && item_i.low_switch |=> offset_q == $past(item_i.encoder_count))
    else $error("zero offset not taken from encoder on low switch");

  a_mode_keeps_memory : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !item_i.action && (is_ground || is_stash)
    |=> $stable(prev_err_q) && $stable(integ_q) && $stable(offset_q))
    else $error("mode request changed PID memory");

endmodule

`default_nettype wire

FILE: rtl/core/lhpc_mix.sv
// ----------------------------------------------------------------------------
// lhpc_mix: PID gain multiply, sum and drive clamp
// Three products summed and limited to the drive range, or the fixed mode
// drive, registered into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lhpc_mix (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lhpc_pkg::cfg_t        cfg_i,
  input  wire lhpc_pkg::stage_t      stage_i,
  input  wire logic                  load_i,
  input  wire logic                  out_valid_i,
  output logic signed [7:0]          drive_o,
  output logic                       at_target_o
);
  import lhpc_pkg::*;

  logic signed [GainW+ErrW-1:0] prod_p;
  logic signed [GainW+IntW-1:0] prod_i;
  logic signed [GainW+DerW-1:0] prod_d;
  logic signed [SumW-1:0]       u_sum;
  logic signed [DrvW-1:0]       pid_drive;
  logic signed [DrvW-1:0]       drive_q, drive_d;
  logic                         done_q, done_d;

  always_comb begin
    prod_p = cfg_i.gain_p * stage_i.err;
    prod_i = cfg_i.gain_i * stage_i.integ;
    prod_d = cfg_i.gain_d * stage_i.deriv;
    u_sum  = SumW'(prod_p) + SumW'(prod_i) + SumW'(prod_d);
    // +-127 then +-80 collapses to a single +-80 limit
    if (u_sum > SumW'(DRIVE_MAX)) begin
      pid_drive = DRIVE_MAX;
    end else if (u_sum < SumW'(DRIVE_MIN)) begin
      pid_drive = DRIVE_MIN;
    end else begin
      pid_drive = u_sum[DrvW-1:0];
    end
  end

  always_comb begin
    drive_d = drive_q;
    done_d  = done_q;
    if (load_i) begin
      drive_d = stage_i.use_pid ? pid_drive : stage_i.fixed_drive;
      done_d  = stage_i.done;
    end
  end

  always_ff @(posedge clk_i) begin
    drive_q <= drive_d;
    done_q  <= done_d;
  end

  assign drive_o     = drive_q;
  assign at_target_o = done_q;

  a_drive_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (drive_q <= DRIVE_MAX) && (drive_q >= DRIVE_MIN))
    else $error("drive outside clamp range");

  a_fixed_drive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && !stage_i.use_pid |=> drive_q == $past(stage_i.fixed_drive))
    else $error("mode drive not passed through");

endmodule

`default_nettype wire

FILE: rtl/core/lift_height_pid_controller.sv
// ----------------------------------------------------------------------------
// lift_height_pid_controller: lift height control with PID and limit modes
// Input register, configuration registers and pipeline handshake around the
// front stage and the multiply stage.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one control tick request:
//   action, target height, encoder count and both limit switches. Output
//   channel (out_valid_o / out_stall_i) returns one drive and at_target per
//   request, in order.
//   Requests pass through the input register, the front stage (mode decode,
//   error, integral, derivative and memory update) and the result register
//   after the gain multiplies. Throughput is one request per cycle while
//   in_stall_o is low; the controller memory is read and written within the
//   front stage, so consecutive ticks chain without gaps.
//   A stalled output holds its result; each stage still fills while a later
//   one waits, and in_stall_o rises only when all three stages hold data.
//   Configuration writes (cfg_valid_i / cfg_ready_o) are always taken and
//   should be made with the pipeline empty.
//   Reset clears the pipeline, the PID memory and the zero offset, sets all
//   registers to 0 and the stash code to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lift_height_pid_controller (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               action_i,
  input  wire logic signed [lhpc_pkg::PosW-1:0]   target_height_i,
  input  wire logic signed [lhpc_pkg::PosW-1:0]   encoder_count_i,
  input  wire logic                               low_switch_i,
  input  wire logic                               high_switch_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [lhpc_pkg::DrvW-1:0]        drive_o,
  output logic                                    at_target_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [lhpc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [lhpc_pkg::CfgDataW-1:0]      cfg_wdata_i
);
  import lhpc_pkg::*;

  cfg_t     cfg_q, cfg_d;
  in_item_t item_q, item_d;
  stage_t   stage;
  logic     s0_v_q, s0_v_d, s1_v_q, s1_v_d, out_v_q, out_v_d;
  logic     en0, en1, en2, in_acc;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_GAIN_P:     cfg_d.gain_p         = cfg_wdata_i[GainW-1:0];
        CFG_GAIN_I:     cfg_d.gain_i         = cfg_wdata_i[GainW-1:0];
        CFG_GAIN_D:     cfg_d.gain_d         = cfg_wdata_i[GainW-1:0];
        CFG_BAND:       cfg_d.arrive_band    = cfg_wdata_i[BandW-1:0];
        CFG_FLOOR:      cfg_d.integral_floor = cfg_wdata_i[FloorW-1:0];
        CFG_GND_CODE:   cfg_d.ground_code    = cfg_wdata_i[PosW-1:0];
        CFG_STASH_CODE: cfg_d.stash_code     = cfg_wdata_i[PosW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // pipeline advance: each stage moves when the next one is free or moving
  always_comb begin
    en2    = !out_v_q || !out_stall_i;
    en1    = !s1_v_q || en2;
    en0    = !s0_v_q || en1;
    in_acc = in_valid_i && en0;
    s0_v_d = en0 ? in_valid_i : s0_v_q;
    s1_v_d = en1 ? s0_v_q : s1_v_q;
    out_v_d = en2 ? s1_v_q : out_v_q;
  end

  always_comb begin
    item_d = item_q;
    if (in_acc) begin
      item_d.action        = action_i;
      item_d.target_height = target_height_i;
      item_d.encoder_count = encoder_count_i;
      item_d.low_switch    = low_switch_i;
      item_d.high_switch   = high_switch_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s0_v_q  <= s0_v_d;
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign in_stall_o  = !en0;
  assign out_valid_o = out_v_q;

  lhpc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .item_i  (item_q),
    .step_i  (en1 && s0_v_q),
    .stage_o (stage)
  );

  lhpc_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .stage_i     (stage),
    .load_i      (en2 && s1_v_q),
    .out_valid_i (out_v_q),
    .drive_o     (drive_o),
    .at_target_o (at_target_o)
  );

  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s0_v_q && s1_v_q && out_v_q && out_stall_i)
    else $error("input stalled with room in the pipeline");

  a_no_lost_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && out_v_q && out_stall_i |=> s1_v_q && out_v_q)
    else $error("result dropped while output stalled");

  a_front_feeds_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && en2 |=> out_v_q)
    else $error("front stage result not moved to output");

endmodule

`default_nettype wire

FILE: test/lift_height_pid_controller_test.sv
// ----------------------------------------------------------------------------
// lift_height_pid_controller_test: self-checking bench for the lift controller
// Feeds control tick requests and register writes from a queue, predicts the
// drive and at_target of each tick, and checks every result in order while
// both channels pause at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lift_height_pid_controller_test;
  import lhpc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE = 3'd7;  // no register behind it

  localparam int PID_CLAMP   = 127;
  localparam int DRIVE_CLAMP = 80;
  localparam int GND_HOLD    = -7;
  localparam int GND_RUN     = -50;
  localparam int UP_HOLD     = 10;
  localparam int UP_RUN      = 110;

  typedef struct packed {
    logic signed [DrvW-1:0] drive;
    logic                   at_target;
  } drive_res_t;

  typedef enum logic [1:0] {REQ_TICK, REQ_CFG, REQ_DRAIN} req_kind_e;

  typedef struct {
    req_kind_e             kind;
    in_item_t              tick;
    logic [CfgIdxW-1:0]    idx;
    logic [CfgDataW-1:0]   data;
    int                    gap;
    bit                    calm;
  } req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic action_i = 1'b0;
  logic signed [PosW-1:0] target_height_i = '0;
  logic signed [PosW-1:0] encoder_count_i = '0;
  logic low_switch_i = 1'b0;
  logic high_switch_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [DrvW-1:0] drive_o;
  logic at_target_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  lift_height_pid_controller uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .target_height_i (target_height_i),
    .encoder_count_i (encoder_count_i),
    .low_switch_i    (low_switch_i),
    .high_switch_i   (high_switch_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .drive_o         (drive_o),
    .at_target_o     (at_target_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  cfg_t                   reg_shadow;
  logic signed [IntW-1:0] pid_prev_err;
  logic signed [IntW-1:0] pid_integral;
  logic signed [PosW-1:0] height_offset;
  int n_ground, n_stash, n_pid, n_clear;

  req_t       pending_q[$];
  drive_res_t expected_drive_q[$];
  int ticks_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int fail_cnt = 0;
  int cycle_cnt = 0;
  bit stim_done = 1'b0;
  bit calm = 1'b0;

  // stimulus builder state
  logic [PosW-1:0] gnd_sh;
  logic [PosW-1:0] stash_sh;
  bit calm_mode;
  int queued_ticks = 0;

  function automatic longint clamp_l(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint mag_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      CFG_GAIN_P:     reg_shadow.gain_p = data[GainW-1:0];
      CFG_GAIN_I:     reg_shadow.gain_i = data[GainW-1:0];
      CFG_GAIN_D:     reg_shadow.gain_d = data[GainW-1:0];
      CFG_BAND:       reg_shadow.arrive_band = data[BandW-1:0];
      CFG_FLOOR:      reg_shadow.integral_floor = data[FloorW-1:0];
      CFG_GND_CODE:   reg_shadow.ground_code = data[PosW-1:0];
      CFG_STASH_CODE: reg_shadow.stash_code = data[PosW-1:0];
      default: ;
    endcase
  endfunction

  function automatic drive_res_t predict_drive(in_item_t t);
    drive_res_t r;
    longint tgt, enc, err, integ, deriv, u, band, flr;
    r = '0;
    tgt = longint'($signed(t.target_height));
    if (t.action) begin
      pid_prev_err = '0;
      pid_integral = '0;
      n_clear++;
    end else if (t.target_height == reg_shadow.ground_code) begin
      // ground code wins when both codes are equal
      r.drive = t.low_switch ? DrvW'(GND_HOLD) : DrvW'(GND_RUN);
      r.at_target = t.low_switch;
      n_ground++;
    end else if (t.target_height == reg_shadow.stash_code) begin
      r.drive = DrvW'(clamp_l(t.high_switch ? UP_HOLD : UP_RUN, -DRIVE_CLAMP, DRIVE_CLAMP));
      r.at_target = t.high_switch;
      n_stash++;
    end else begin
      if (t.low_switch) height_offset = t.encoder_count;
      enc = longint'($signed(t.encoder_count));
      err = tgt - (enc - longint'($signed(height_offset)));
      integ = clamp_l(longint'($signed(pid_integral)) + err,
                      longint'($signed(INT_MIN)), longint'($signed(INT_MAX)));
      band = longint'(reg_shadow.arrive_band);
      flr = longint'(reg_shadow.integral_floor);
      if (mag_l(err) <= tgt + band || mag_l(integ) <= flr) integ = 0;
      pid_integral = IntW'(integ);
      deriv = err - longint'($signed(pid_prev_err));
      u = longint'($signed(reg_shadow.gain_p)) * err
        + longint'($signed(reg_shadow.gain_i)) * integ
        + longint'($signed(reg_shadow.gain_d)) * deriv;
      u = clamp_l(u, -PID_CLAMP, PID_CLAMP);
      u = clamp_l(u, -DRIVE_CLAMP, DRIVE_CLAMP);
      pid_prev_err = IntW'(err);
      r.drive = DrvW'(u);
      r.at_target = (mag_l(err) <= band);
      n_pid++;
    end
    return r;
  endfunction

  // ---------------- stimulus builders ----------------

  function automatic int spread(int lo, int hi);
    return int'($urandom_range(0, hi - lo)) + lo;
  endfunction

  function automatic logic [PosW-1:0] pick_pos();
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2, 3: return PosW'(spread(-200, 200));
      default: return PosW'($urandom);
    endcase
  endfunction

  task automatic add_tick(logic act, logic [PosW-1:0] tgt, logic [PosW-1:0] enc,
                          logic lo, logic hi);
    req_t r;
    r.kind = REQ_TICK;
    r.tick.action = act;
    r.tick.target_height = tgt;
    r.tick.encoder_count = enc;
    r.tick.low_switch = lo;
    r.tick.high_switch = hi;
    r.idx = '0;
    r.data = '0;
    r.gap = calm_mode ? 0 : spread(0, 6);
    r.calm = calm_mode;
    pending_q.push_back(r);
    queued_ticks++;
  endtask

  task automatic add_marker(req_kind_e kind, logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    req_t r;
    r.kind = kind;
    r.tick = '0;
    r.idx = idx;
    r.data = data;
    r.gap = 0;
    r.calm = calm_mode;
    pending_q.push_back(r);
    if (kind == REQ_CFG && idx == CFG_GND_CODE) gnd_sh = data[PosW-1:0];
    if (kind == REQ_CFG && idx == CFG_STASH_CODE) stash_sh = data[PosW-1:0];
  endtask

  task automatic set_phase(int gp, int gi, int gd, int band, int flr, int gnd, int stash,
                           bit spare);
    add_marker(REQ_CFG, CFG_GAIN_P, CfgDataW'(gp));
    add_marker(REQ_CFG, CFG_GAIN_I, CfgDataW'(gi));
    add_marker(REQ_CFG, CFG_GAIN_D, CfgDataW'(gd));
    add_marker(REQ_CFG, CFG_BAND, CfgDataW'(band));
    add_marker(REQ_CFG, CFG_FLOOR, CfgDataW'(flr));
    add_marker(REQ_CFG, CFG_GND_CODE, CfgDataW'(gnd));
    add_marker(REQ_CFG, CFG_STASH_CODE, CfgDataW'(stash));
    if (spare) add_marker(REQ_CFG, CFG_IDX_SPARE, CfgDataW'($urandom));
  endtask

  task automatic add_random_tick();
    logic [PosW-1:0] tgt, enc;
    int k;
    k = spread(0, 19);
    if (k == 0) tgt = gnd_sh;
    else if (k == 1) tgt = stash_sh;
    else tgt = pick_pos();
    if (spread(0, 1) == 1) enc = tgt + PosW'(spread(-300, 300));
    else enc = pick_pos();
    add_tick(spread(0, 24) == 0, tgt, enc, spread(0, 5) == 0, spread(0, 1) == 1);
  endtask

  // lift zeroed on the bottom switch, then climbing toward a height target
  task automatic add_approach();
    int base, goal, h, n, k;
    base = spread(-4000000, 4000000);
    goal = spread(-20000, 20000);
    h = 0;
    n = spread(8, 24);
    add_tick(1'b0, PosW'(goal), PosW'(base), 1'b1, 1'b0);
    for (k = 1; k < n; k++) begin
      h = h + (goal - h) / 3 + spread(-5, 5);
      add_tick(spread(0, 40) == 0, PosW'(goal), PosW'(base + h), 1'b0, spread(0, 7) == 0);
    end
  endtask

  // ---------------- driver ----------------

  req_t     head;
  in_item_t cur_tick;
  int       gap_left = 0;
  bit       next_in_valid, next_cfg_valid, drained;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      next_in_valid  = in_valid_i;
      next_cfg_valid = cfg_valid_i;
      drained = !in_valid_i && (ticks_sent == results_seen);
      if (in_valid_i && !in_stall_o) begin
        expected_drive_q.push_back(predict_drive(cur_tick));
        ticks_sent <= ticks_sent + 1;
        next_in_valid = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        write_register(cfg_index_i, cfg_wdata_i);
        reg_writes++;
        next_cfg_valid = 1'b0;
      end
      if (!next_in_valid && !next_cfg_valid && pending_q.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          head = pending_q[0];
          case (head.kind)
            REQ_TICK: begin
              pending_q.delete(0);
              cur_tick = head.tick;
              action_i <= head.tick.action;
              target_height_i <= head.tick.target_height;
              encoder_count_i <= head.tick.encoder_count;
              low_switch_i <= head.tick.low_switch;
              high_switch_i <= head.tick.high_switch;
              next_in_valid = 1'b1;
              gap_left = head.gap;
              calm <= head.calm;
            end
            REQ_CFG: begin
              // registers change only with the pipeline empty
              if (drained) begin
                pending_q.delete(0);
                cfg_index_i <= head.idx;
                cfg_wdata_i <= head.data;
                next_cfg_valid = 1'b1;
              end
            end
            default: begin
              if (drained) begin
                pending_q.delete(0);
                stim_done <= (pending_q.size() == 0);
              end
            end
          endcase
        end
      end
      in_valid_i  <= next_in_valid;
      cfg_valid_i <= next_cfg_valid;
    end
  end

  // ---------------- monitor ----------------

  drive_res_t exp_res;
  int         stall_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (results_seen >= ticks_sent) begin
          $error("unexpected result: drive %0d at_target %0b", drive_o, at_target_o);
          fail_cnt++;
        end else begin
          exp_res = expected_drive_q.pop_front();
          results_seen <= results_seen + 1;
          if (drive_o !== exp_res.drive) begin
            $error("drive: expected %0d, got %0d", exp_res.drive, drive_o);
            fail_cnt++;
          end
          if (at_target_o !== exp_res.at_target) begin
            $error("at_target: expected %0b, got %0b", exp_res.at_target, at_target_o);
            fail_cnt++;
          end
        end
        stall_left = calm ? 0 : spread(0, 6);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    int ph, target_cnt;
    reg_shadow = '0;
    reg_shadow.stash_code = 1;
    pid_prev_err = '0;
    pid_integral = '0;
    height_offset = '0;
    gnd_sh = '0;
    stash_sh = 24'd1;
    calm_mode = 1'b0;

    // directed: reset registers, both modes and the PID path
    add_tick(1'b0, 24'd0, 24'd5, 1'b0, 1'b0);
    add_tick(1'b0, 24'd0, 24'd5, 1'b1, 1'b1);
    add_tick(1'b0, 24'd1, 24'd5, 1'b0, 1'b0);
    add_tick(1'b0, 24'd1, 24'd5, 1'b0, 1'b1);
    add_tick(1'b0, 24'h7FFFFF, 24'h800000, 1'b0, 1'b1);
    add_tick(1'b0, 24'h800000, 24'h7FFFFF, 1'b1, 1'b0);
    add_tick(1'b1, 24'h7FFFFF, 24'h800000, 1'b1, 1'b1);
    set_phase(3, 1, 2, 50, 100, -8388608, 8388607, 1'b1);
    add_tick(1'b0, 24'h800000, 24'd0, 1'b1, 1'b0);
    add_tick(1'b0, 24'h7FFFFF, 24'd0, 1'b0, 1'b0);
    add_tick(1'b0, 24'd100, 24'd0, 1'b1, 1'b0);
    add_tick(1'b0, 24'd100, 24'd60, 1'b0, 1'b0);
    add_tick(1'b0, 24'd100, 24'd150, 1'b0, 1'b1);
    add_tick(1'b0, 24'd100, 24'd151, 1'b0, 1'b0);
    add_tick(1'b0, -24'sd30, 24'd40, 1'b0, 1'b0);
    add_tick(1'b1, 24'd100, 24'd0, 1'b0, 1'b0);
    add_tick(1'b1, 24'h800000, 24'd0, 1'b1, 1'b0);  // clear beats ground mode
    set_phase(5, -2, 1, 10, 0, 5, 5, 1'b0);
    add_tick(1'b0, 24'd5, 24'd0, 1'b0, 1'b1);        // equal codes: ground wins
    add_tick(1'b0, 24'd5, 24'd0, 1'b1, 1'b1);

    // random phases, one register setting each
    for (ph = 0; ph < 9; ph++) begin
      calm_mode = 1'b0;
      case (ph)
        0: set_phase(32767, 32767, 32767, 0, 0, -8388608, 8388607, 1'b0);
        1: set_phase(-32768, -32768, -32768, 8388607, 2147483647, 8388607, -8388608, 1'b1);
        2: begin
          target_cnt = spread(-300, 300);
          set_phase(spread(-40, 40), spread(-40, 40), spread(-40, 40), spread(0, 300),
                    spread(0, 20000), target_cnt, target_cnt, 1'b0);
        end
        default: set_phase((ph % 2) ? spread(-3000, 3000) : spread(-40, 40),
                           (ph % 2) ? spread(-3000, 3000) : spread(-40, 40),
                           (ph % 2) ? spread(-3000, 3000) : spread(-40, 40),
                           (ph == 6) ? int'($urandom_range(0, 8388607)) : spread(0, 300),
                           (ph == 7) ? int'($urandom_range(0, 2147483647)) : spread(0, 20000),
                           spread(-300, 300), spread(-300, 300), ph == 5);
      endcase
      calm_mode = (ph % 3 == 2);
      target_cnt = queued_ticks + 150;
      while (queued_ticks < target_cnt) begin
        if (spread(0, 9) < 6) add_approach();
        else repeat (spread(1, 4)) add_random_tick();
        // hold off until the pipeline has fully drained
        if (ph == 4 && queued_ticks >= target_cnt - 75 && queued_ticks < target_cnt - 60)
          add_marker(REQ_DRAIN, '0, '0);
      end
    end

    // long one-sided error runs drive the integral into both saturation limits
    calm_mode = 1'b0;
    set_phase(2, 1, -1, 0, 0, 0, 1, 1'b0);
    add_tick(1'b0, 24'd100, 24'h800000, 1'b1, 1'b0);
    repeat (100) add_tick(1'b0, 24'h800000, 24'h7FFFFF, 1'b0, 1'b0);
    add_tick(1'b1, 24'd100, 24'd0, 1'b0, 1'b0);
    add_tick(1'b0, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b0);
    repeat (100) add_tick(1'b0, 24'h7FFFFF, 24'h800000, 1'b0, 1'b0);
    add_marker(REQ_DRAIN, '0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!stim_done) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (expected_drive_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_drive_q.size());
      fail_cnt++;
    end
    $display("Checked %0d ticks: %0d ground, %0d stash, %0d PID, %0d clear; %0d register writes",
             results_seen, n_ground, n_stash, n_pid, n_clear, reg_writes);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/lhpc_pkg.sv
rtl/core/lhpc_front.sv
rtl/core/lhpc_mix.sv
rtl/core/lift_height_pid_controller.sv
test/lift_height_pid_controller_test.sv
